// File: sv/mcp_pkg.sv
// mcp_pkg: shared types and constants for the midi channel message parser
// no dependencies; imported by every module of the block

package mcp_pkg;

   localparam int MCP_QUEUE_DEPTH = 2;

   localparam logic [7:0] CLOCK_BYTE      = 8'hF8;
   localparam logic [7:0] SYS_COMMON_BASE = 8'hF0;

   // status nibbles of channel messages
   localparam logic [3:0] ST_NOTE_OFF      = 4'h8;
   localparam logic [3:0] ST_NOTE_ON       = 4'h9;
   localparam logic [3:0] ST_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] ST_CONTROL       = 4'hB;
   localparam logic [3:0] ST_PROGRAM       = 4'hC;
   localparam logic [3:0] ST_CHAN_PRESSURE = 4'hD;
   localparam logic [3:0] ST_PITCH_BEND    = 4'hE;

   typedef logic [4:0] chan_type;
   typedef logic [6:0] data_type;

   typedef enum logic [2:0] {
      EV_CLOCK      = 3'd0,
      EV_NOTE_OFF   = 3'd1,
      EV_NOTE_ON    = 3'd2,
      EV_CONTROL    = 3'd3,
      EV_PROGRAM    = 3'd4,
      EV_PITCH_BEND = 3'd5
   } event_type;

   // one classified message handed from the parser to the formatter
   typedef struct packed {
      event_type kind;
      chan_type  channel;
      data_type  d0;
      data_type  d1;
   } msg_type;

endpackage

// File: sv/mcp_req_if.sv
// mcp_req_if: valid/ready channel carrying one received midi byte
// no dependencies

interface mcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// File: sv/mcp_rsp_if.sv
// mcp_rsp_if: valid/ready channel carrying one decoded midi event
// no dependencies

interface mcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         event_res;
   logic [4:0]         midi_channel;
   logic [6:0]         first_data;
   logic [6:0]         second_data;
   logic signed [13:0] bend_value;

   modport source (output valid, output event_res, output midi_channel, output first_data,
                   output second_data, output bend_value, input ready);
   modport sink (input valid, input event_res, input midi_channel, input first_data,
                 input second_data, input bend_value, output ready);
endinterface

// File: sv/mcp_parser.sv
// mcp_parser: front end, tracks running status and builds complete messages
// depends on mcp_pkg and mcp_req_if

module mcp_parser (
   input  logic             clock,
   input  logic             reset,
   mcp_req_if.sink          req_chan,
   input  logic             queue_full,
   output logic             push_valid,
   output mcp_pkg::msg_type push_msg
);
   import mcp_pkg::*;

   logic [7:0] running_status_ff, running_status_in;
   logic [1:0] data_count_ff, data_count_in;
   logic [1:0] expected_count_ff, expected_count_in;
   data_type   held_data_ff, held_data_in;

   logic       accept;
   logic       finish;
   data_type   fin_d0;
   data_type   fin_d1;
   logic [7:0] b;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign b              = req_chan.rx_byte;

   always_comb begin
      running_status_in = running_status_ff;
      data_count_in     = data_count_ff;
      expected_count_in = expected_count_ff;
      held_data_in      = held_data_ff;
      finish            = 1'b0;
      fin_d0            = '0;
      fin_d1            = '0;
      push_valid        = 1'b0;
      push_msg.kind     = EV_CLOCK;
      push_msg.channel  = '0;
      push_msg.d0       = '0;
      push_msg.d1       = '0;

      if (accept) begin
         if (b >= CLOCK_BYTE) begin
            // real-time bytes leave the parse state alone
            push_valid = (b == CLOCK_BYTE);
         end else if (b[7]) begin
            data_count_in = 2'd0;
            if (b >= SYS_COMMON_BASE) begin
               running_status_in = '0;
               expected_count_in = 2'd0;
            end else begin
               running_status_in = b;
               expected_count_in = (b[7:4] inside {ST_PROGRAM, ST_CHAN_PRESSURE}) ? 2'd1 : 2'd2;
            end
         end else if (running_status_ff != '0) begin
            if (data_count_ff == 2'd0) begin
               held_data_in = b[6:0];
               if (expected_count_ff <= 2'd1) begin
                  finish = 1'b1;
                  fin_d0 = b[6:0];
               end else begin
                  data_count_in = 2'd1;
               end
            end else begin
               data_count_in = 2'd0;
               finish        = 1'b1;
               fin_d0        = held_data_ff;
               fin_d1        = b[6:0];
            end
         end
      end

      if (finish) begin
         push_msg.channel = {1'b0, running_status_ff[3:0]} + 5'd1;
         push_msg.d0      = fin_d0;
         push_msg.d1      = fin_d1;
         case (running_status_ff[7:4])
            ST_NOTE_OFF: begin
               push_valid    = 1'b1;
               push_msg.kind = EV_NOTE_OFF;
            end
            ST_NOTE_ON: begin
               push_valid    = 1'b1;
               push_msg.kind = (fin_d1 == '0) ? EV_NOTE_OFF : EV_NOTE_ON;
            end
            ST_CONTROL: begin
               push_valid    = 1'b1;
               push_msg.kind = EV_CONTROL;
            end
            ST_PROGRAM: begin
               push_valid    = 1'b1;
               push_msg.kind = EV_PROGRAM;
            end
            ST_PITCH_BEND: begin
               push_valid    = 1'b1;
               push_msg.kind = EV_PITCH_BEND;
            end
            // pressure messages are parsed and dropped
            default: begin
               push_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= '0;
         data_count_ff     <= 2'd0;
         expected_count_ff <= 2'd0;
      end else begin
         running_status_ff <= running_status_in;
         data_count_ff     <= data_count_in;
         expected_count_ff <= expected_count_in;
      end
      held_data_ff <= held_data_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      data_count_ff <= 2'd1)
      else $error("data count beyond one");

   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      running_status_ff == '0 |-> data_count_ff == 2'd0 && expected_count_ff == 2'd0)
      else $error("data count without running status");

   a_status_msb: assert property (@(posedge clock) disable iff (reset)
      running_status_ff == '0 || (running_status_ff[7] && running_status_ff < SYS_COMMON_BASE))
      else $error("running status holds a non-channel byte");

endmodule

// File: sv/mcp_msg_queue.sv
// mcp_msg_queue: short fifo between the parser and the event formatter
// depends on mcp_pkg

module mcp_msg_queue #(
   parameter int DEPTH = mcp_pkg::MCP_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  mcp_pkg::msg_type push_msg,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output mcp_pkg::msg_type head_msg
);
   import mcp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   msg_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_msg   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_msg;
      end
   end

endmodule

// File: sv/mcp_formatter.sv
// mcp_formatter: back end, channel filter and event formatting into the output register
// depends on mcp_pkg and mcp_rsp_if

module mcp_formatter (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  mcp_pkg::chan_type csr_wr_data,
   input  logic             head_valid,
   input  mcp_pkg::msg_type head_msg,
   output logic             pop,
   mcp_rsp_if.source        rsp_chan
);
   import mcp_pkg::*;

   chan_type           listen_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   event_type          event_ff;
   chan_type           channel_ff;
   data_type           first_ff;
   data_type           second_ff;
   logic signed [13:0] bend_ff;

   logic               out_free;
   logic               pass;
   logic               load;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = head_valid && out_free;
   assign pass     = (head_msg.kind == EV_CLOCK) || (listen_ff == '0)
                     || (listen_ff == head_msg.channel);
   assign load     = pop && pass;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            listen_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         event_ff   <= head_msg.kind;
         channel_ff <= head_msg.channel;
         first_ff   <= (head_msg.kind inside {EV_PITCH_BEND, EV_CLOCK}) ? '0 : head_msg.d0;
         second_ff  <= (head_msg.kind inside {EV_NOTE_ON, EV_CONTROL}) ? head_msg.d1 : '0;
         // raw 14-bit value minus 8192 is the raw value with its top bit flipped
         bend_ff    <= (head_msg.kind == EV_PITCH_BEND)
                       ? {~head_msg.d1[6], head_msg.d1[5:0], head_msg.d0} : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_res    = event_ff;
   assign rsp_chan.midi_channel = channel_ff;
   assign rsp_chan.first_data   = first_ff;
   assign rsp_chan.second_data  = second_ff;
   assign rsp_chan.bend_value   = bend_ff;

   a_clock_no_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff == EV_CLOCK |-> channel_ff == '0 && first_ff == '0)
      else $error("clock event with channel or data");

   a_bend_only_on_bend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff != EV_PITCH_BEND |-> bend_ff == '0)
      else $error("bend value on a non-bend event");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded event not presented");

endmodule

// File: sv/midi_channel_message_parser.sv
// midi_channel_message_parser: top level, parser front end, message queue, formatter
// depends on mcp_pkg, mcp_req_if, mcp_rsp_if, mcp_parser, mcp_msg_queue, mcp_formatter
//
// usage
//   req_chan carries one received midi byte per request (valid/ready)
//   rsp_chan carries one decoded event per request: clock, note off, note on,
//     control change, program change or pitch bend (bend centered to signed)
//   csr_wr_en/csr_wr_data set the listen channel: 0 is omni, 1..16 a single channel
//   bytes are taken one per cycle while req_chan.ready is high; the byte that completes
//     an event pushes it into the queue, which feeds the rsp_chan output register
//   most bytes make no event; real-time bytes other than timing clock are ignored
//   parse state update sets throughput: one byte per cycle while the queue is not full
//   when the receiver stalls, events wait in the output register and the queue;
//     once the queue is full req_chan.ready drops until an event is taken
//   reset clears running status, counts, the queue and the listen channel (omni)
//   change the listen channel only while no event is pending

module midi_channel_message_parser #(
   parameter int QUEUE_DEPTH = mcp_pkg::MCP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   mcp_req_if.sink           req_chan,
   mcp_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  mcp_pkg::chan_type csr_wr_data
);
   import mcp_pkg::*;

   logic    queue_full;
   logic    push_valid;
   msg_type push_msg;
   logic    pop;
   logic    head_valid;
   msg_type head_msg;

   mcp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_msg   (push_msg)
   );

   mcp_msg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_msg   (push_msg),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_msg   (head_msg)
   );

   mcp_formatter u_formatter (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_valid  (head_valid),
      .head_msg    (head_msg),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

// File: tb/mcp_checker.sv
`timescale 1ns / 1ps
// mcp_checker: watches the byte and event channels and decodes every accepted byte on its own
// compares each event taken from the block; depends on mcp_pkg, mcp_req_if, mcp_rsp_if

module mcp_checker (
   input  logic              clock,
   input  logic              reset,
   mcp_req_if                req_mon,
   mcp_rsp_if                rsp_mon,
   input  logic              csr_wr_en,
   input  mcp_pkg::chan_type csr_wr_data,
   output int                fail_count,
   output int                outstanding_events
);
   import mcp_pkg::*;

   typedef struct packed {
      event_type          kind;
      chan_type           channel;
      data_type           d_first;
      data_type           d_second;
      logic signed [13:0] bend;
   } midi_event_type;

   midi_event_type pending_events[$];
   int             mismatches;

   // decoder state
   chan_type   listen;
   logic [7:0] running_status;
   logic [1:0] data_count;
   logic [1:0] expected_count;
   data_type   held_byte;

   function automatic void clear_event(output midi_event_type ev);
      ev.kind     = EV_CLOCK;
      ev.channel  = '0;
      ev.d_first  = '0;
      ev.d_second = '0;
      ev.bend     = '0;
   endfunction

   function automatic bit close_message(input data_type d0, input data_type d1,
                                        output midi_event_type ev);
      chan_type ch;
      bit       hit;
      clear_event(ev);
      ch  = {1'b0, running_status[3:0]} + 5'd1;
      hit = 1'b1;
      if (listen != '0 && listen != ch) return 1'b0;
      ev.channel = ch;
      ev.d_first = d0;
      case (running_status[7:4])
         ST_NOTE_OFF: ev.kind = EV_NOTE_OFF;
         ST_NOTE_ON: begin
            if (d1 == '0) begin
               ev.kind = EV_NOTE_OFF;
            end else begin
               ev.kind     = EV_NOTE_ON;
               ev.d_second = d1;
            end
         end
         ST_CONTROL: begin
            ev.kind     = EV_CONTROL;
            ev.d_second = d1;
         end
         ST_PROGRAM: ev.kind = EV_PROGRAM;
         ST_PITCH_BEND: begin
            ev.kind    = EV_PITCH_BEND;
            ev.d_first = '0;
            ev.bend    = {d1, d0} - 14'd8192;
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic bit decode_midi_byte(input logic [7:0] b, output midi_event_type ev);
      clear_event(ev);
      // real-time bytes leave the parse state alone
      if (b >= CLOCK_BYTE) return (b == CLOCK_BYTE);
      if (b[7]) begin
         data_count = '0;
         if (b >= SYS_COMMON_BASE) begin
            running_status = '0;
            expected_count = '0;
         end else begin
            running_status = b;
            expected_count = (b[7:4] == ST_PROGRAM || b[7:4] == ST_CHAN_PRESSURE) ? 2'd1 : 2'd2;
         end
         return 1'b0;
      end
      if (running_status == '0) return 1'b0;
      if (data_count == '0) begin
         held_byte  = b[6:0];
         data_count = 2'd1;
         if (expected_count <= 2'd1) begin
            data_count = '0;
            return close_message(b[6:0], '0, ev);
         end
         return 1'b0;
      end
      data_count = '0;
      return close_message(held_byte, b[6:0], ev);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      midi_event_type got_ev;
      midi_event_type want_ev;
      midi_event_type new_ev;
      if (reset) begin
         pending_events.delete();
         mismatches     = 0;
         listen         = '0;
         running_status = '0;
         data_count     = '0;
         expected_count = '0;
         held_byte      = '0;
      end else begin
         // compare first: an event never leaves in the cycle its byte arrives
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_ev.kind     = event_type'(rsp_mon.event_res);
            got_ev.channel  = rsp_mon.midi_channel;
            got_ev.d_first  = rsp_mon.first_data;
            got_ev.d_second = rsp_mon.second_data;
            got_ev.bend     = rsp_mon.bend_value;
            if (pending_events.size() == 0) begin
               $error("event with none expected: kind %0d channel %0d",
                      rsp_mon.event_res, rsp_mon.midi_channel);
               mismatches++;
            end else begin
               want_ev = pending_events.pop_front();
               check_field("event_res", int'(want_ev.kind), int'(got_ev.kind));
               check_field("midi_channel", int'(want_ev.channel), int'(got_ev.channel));
               check_field("first_data", int'(want_ev.d_first), int'(got_ev.d_first));
               check_field("second_data", int'(want_ev.d_second), int'(got_ev.d_second));
               check_field("bend_value", int'(want_ev.bend), int'(got_ev.bend));
            end
         end
         if (csr_wr_en) listen = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            if (decode_midi_byte(req_mon.rx_byte, new_ev)) pending_events.push_back(new_ev);
         end
      end
      fail_count         <= mismatches;
      outstanding_events <= pending_events.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: byte stimulus, event receiver and verdict for midi_channel_message_parser
// depends on mcp_pkg, mcp_req_if, mcp_rsp_if, mcp_checker and the block itself

module tb_top;
   import mcp_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SEGMENT_BYTES = 250;

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   chan_type csr_wr_data;

   int fail_count;
   int outstanding_events;
   int cycle_count;
   int req_idle_pct;
   int rsp_idle_pct;
   int bytes_sent;

   logic [7:0] last_status;
   bit         status_live;

   mcp_req_if req_chan ();
   mcp_rsp_if rsp_chan ();

   midi_channel_message_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mcp_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_chan),
      .rsp_mon            (rsp_chan),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .outstanding_events (outstanding_events)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // stop sending and let every expected event come out, plus the pipeline depth
   task automatic drain_events();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_events != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_listen(input chan_type value);
      drain_events();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] rand_data();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'h7F;
         default: return 8'($urandom_range(127));
      endcase
   endfunction

   // mostly well-formed messages with random content, some noise and cut-off messages
   task automatic send_random_message(input chan_type listen);
      logic [3:0] kind;
      logic [3:0] chan;
      int         len;
      int         sel;
      sel = $urandom_range(99);
      if (sel < 6) begin
         send_byte(8'($urandom_range(255)));
         status_live = 1'b0;
      end else if (sel < 12) begin
         send_byte(SYS_COMMON_BASE + 8'($urandom_range(7)));
         send_byte(rand_data());
         status_live = 1'b0;
      end else begin
         if (!status_live || $urandom_range(3) == 0) begin
            kind = ST_NOTE_OFF + 4'($urandom_range(6));
            chan = 4'($urandom_range(15));
            if (listen >= 5'd1 && listen <= 5'd16 && $urandom_range(1) == 1)
               chan = 4'(listen - 5'd1);
            last_status = {kind, chan};
            status_live = 1'b1;
            send_byte(last_status);
         end
         len = (last_status[7:4] == ST_PROGRAM || last_status[7:4] == ST_CHAN_PRESSURE) ? 1 : 2;
         if (len == 2 && $urandom_range(19) == 0) len = 1;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(14) == 0) send_byte(CLOCK_BYTE + 8'($urandom_range(7)));
            send_byte(rand_data());
         end
      end
   endtask

   initial begin
      logic [7:0] omni_bytes[$];
      logic [7:0] chan16_bytes[$];
      logic [7:0] none_bytes[$];
      chan_type   listen_plan[6];
      int         seg_start;

      reset          = 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_idle_pct     = 19;
      rsp_idle_pct     = 50;
      bytes_sent       = 0;
      status_live      = 1'b0;
      last_status      = 8'h00;

      // data with no status, clock, ignored real-time inside a message, velocity zero,
      // every channel message kind, pitch bend extremes, system common dropping data
      omni_bytes = '{8'h45, 8'hF8, 8'h90, 8'h3C, 8'hFE, 8'h40, 8'h3C, 8'h00,
                     8'h80, 8'h7F, 8'h7F, 8'hB5, 8'h00, 8'h7F, 8'hCF, 8'h7F,
                     8'hE0, 8'h00, 8'h00, 8'h7F, 8'h7F, 8'hA1, 8'h10, 8'h20,
                     8'hD2, 8'h30, 8'hF0, 8'h12};
      chan16_bytes = '{8'h9F, 8'h40, 8'h40, 8'h90, 8'h40, 8'h40};
      none_bytes   = '{8'h90, 8'h10, 8'h10};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_listen(5'd0);
      foreach (omni_bytes[i]) send_byte(omni_bytes[i]);
      write_listen(5'd16);
      foreach (chan16_bytes[i]) send_byte(chan16_bytes[i]);
      write_listen(5'd31);
      foreach (none_bytes[i]) send_byte(none_bytes[i]);

      listen_plan = '{5'd0, 5'($urandom_range(1, 16)), 5'd16,
                      5'($urandom_range(17, 31)), 5'd1, 5'($urandom_range(16))};
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin req_idle_pct = 19; rsp_idle_pct = 50; end
            1: begin req_idle_pct = 50; rsp_idle_pct = 19; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         write_listen(listen_plan[seg]);
         status_live = 1'b0;
         seg_start   = bytes_sent;
         while (bytes_sent - seg_start < SEGMENT_BYTES) send_random_message(listen_plan[seg]);
      end

      drain_events();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
